[rtl/delimited_packet_receiver_assert.svh]
// assertion macros for the delimited packet receiver
// used by the top level only, expects i_clk and i_rst_n in scope
`ifndef DELIMITED_PACKET_RECEIVER_ASSERT_SVH
`define DELIMITED_PACKET_RECEIVER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DPR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dpr_pkg.sv]
// shared constants and types for the delimited packet receiver
// no dependencies
package dpr_pkg;

    localparam int PAYLOAD_DEPTH = 32;
    localparam int MAX_RESULTS   = 32;
    localparam int IDX_W         = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int CNT_W         = $clog2(PAYLOAD_DEPTH + 1);
    localparam int RUN_LEN       = (PAYLOAD_DEPTH < MAX_RESULTS) ? PAYLOAD_DEPTH : MAX_RESULTS;
    localparam int RUN_W         = $clog2(RUN_LEN + 1);
    localparam int MEM_ADDR_W    = IDX_W + 1;
    localparam int MEM_DEPTH     = 2 ** MEM_ADDR_W;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [7:0] START_BYTE = 8'h7B;
    localparam logic [7:0] END_BYTE   = 8'h7D;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] command;
        logic [5:0] payload_len;
        logic [4:0] byte_index;
        logic [7:0] payload_byte;
        logic       has_byte;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [7:0]       cmd;
        logic [CNT_W-1:0] len;
        logic             bank;
    } t_job;

    typedef struct packed {
        logic                  en;
        logic [MEM_ADDR_W-1:0] addr;
        logic [7:0]            data;
    } t_mem_wr;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

endpackage

[rtl/dpr_front.sv]
// deframer front end: config registers, phase tracking, timeout, payload writes
// depends on dpr_pkg
module dpr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dpr_pkg::t_item    i_item,
    output logic              o_full,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [dpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dpr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic              o_job_push,
    output dpr_pkg::t_job     o_job,
    output dpr_pkg::t_mem_wr  o_mem_wr,
    input  dpr_pkg::t_release i_release
);
    import dpr_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_CMD, PH_PAY} t_phase;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_cmd, n_cmd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [15:0]      r_timer, n_timer;
    logic             r_bank, n_bank;
    logic [1:0]       r_busy, n_busy;
    logic [15:0]      r_timeout, n_timeout;
    logic             r_enable, n_enable;
    logic             r_job_push, n_job_push;
    t_job             r_job, n_job;
    t_mem_wr          r_mem_wr, n_mem_wr;

    logic        w_accept;
    logic        w_cfg_wr;
    logic [15:0] w_timer_inc;

    assign o_full      = r_busy[r_bank];
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_push && !o_full;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_timer_inc = r_timer + 16'd1;

    assign o_job_push = r_job_push;
    assign o_job      = r_job;
    assign o_mem_wr   = r_mem_wr;

    always_comb begin
        n_phase    = r_phase;
        n_cmd      = r_cmd;
        n_cnt      = r_cnt;
        n_timer    = r_timer;
        n_bank     = r_bank;
        n_busy     = r_busy;
        n_timeout  = r_timeout;
        n_enable   = r_enable;
        n_job_push = 1'b0;
        n_job      = r_job;
        n_mem_wr   = '{en: 1'b0, addr: {r_bank, r_cnt[IDX_W-1:0]}, data: i_item.rx_byte};

        if (w_cfg_wr) begin
            unique case (i_cfg_index)
                CFG_TIMEOUT: n_timeout = i_cfg_data[15:0];
                CFG_ENABLE:  n_enable  = i_cfg_data[0];
                default: ;
            endcase
        end

        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end

        if (w_accept) begin
            if (i_item.req_type == REQ_TICK) begin
                if (r_phase == PH_CMD || r_phase == PH_PAY) begin
                    n_timer = w_timer_inc;
                    if (w_timer_inc >= r_timeout) begin
                        n_phase = PH_IDLE;
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (i_item.rx_byte == START_BYTE) begin
                            n_phase = PH_CMD;
                            n_timer = '0;
                        end
                    end
                    PH_CMD: begin
                        n_cmd   = i_item.rx_byte;
                        n_phase = PH_PAY;
                        n_cnt   = '0;
                        n_timer = '0;
                    end
                    PH_PAY: begin
                        n_timer = '0;
                        if (i_item.rx_byte == END_BYTE) begin
                            n_phase = PH_IDLE;
                            if (r_enable) begin
                                n_job_push     = 1'b1;
                                n_job          = '{cmd: r_cmd, len: r_cnt, bank: r_bank};
                                n_busy[r_bank] = 1'b1;
                                n_bank         = !r_bank;
                            end
                        end else if (r_cnt < CNT_W'(PAYLOAD_DEPTH)) begin
                            n_mem_wr.en = 1'b1;
                            n_cnt       = r_cnt + CNT_W'(1);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_cmd      <= '0;
            r_cnt      <= '0;
            r_timer    <= '0;
            r_bank     <= 1'b0;
            r_busy     <= '0;
            r_timeout  <= TIMEOUT_RESET;
            r_enable   <= 1'b1;
            r_job_push <= 1'b0;
            r_mem_wr   <= '0;
        end else begin
            r_phase    <= n_phase;
            r_cmd      <= n_cmd;
            r_cnt      <= n_cnt;
            r_timer    <= n_timer;
            r_bank     <= n_bank;
            r_busy     <= n_busy;
            r_timeout  <= n_timeout;
            r_enable   <= n_enable;
            r_job_push <= n_job_push;
            r_mem_wr   <= n_mem_wr;
        end
        r_job <= n_job;
    end

endmodule

[rtl/dpr_jobq.sv]
// two-entry queue of completed packet descriptors between front and back
// depends on dpr_pkg
module dpr_jobq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dpr_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output dpr_pkg::t_job o_head
);
    import dpr_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_count, n_count;
    logic       w_push, w_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_head  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wp    = w_push ? !r_wp : r_wp;
        n_rp    = w_pop ? !r_rp : r_rp;
        n_count = r_count + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
        if (w_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

[rtl/dpr_back.sv]
// emission back end: two-bank payload memory, result walker, output register
// depends on dpr_pkg
module dpr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dpr_pkg::t_mem_wr  i_mem_wr,
    input  logic              i_job_valid,
    input  dpr_pkg::t_job     i_job,
    output logic              o_job_pop,
    output dpr_pkg::t_release o_release,
    output logic              o_active,
    output logic              o_empty,
    input  logic              i_pop,
    output dpr_pkg::t_result  o_result
);
    import dpr_pkg::*;

    typedef enum logic [1:0] {B_IDLE, B_READ, B_PUT} t_bstate;

    logic [7:0] r_mem [MEM_DEPTH];
    logic [7:0] r_rd_data;

    t_bstate          r_state, n_state;
    t_job             r_job, n_job;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [RUN_W-1:0] r_run, n_run;
    t_result          r_out, n_out;
    logic             r_ovalid, n_ovalid;
    t_release         r_release, n_release;

    logic             w_rd_en;
    logic             w_load;
    logic             w_last;
    logic [RUN_W-1:0] w_next;

    assign o_job_pop = (r_state == B_IDLE) && i_job_valid;
    assign o_release = r_release;
    assign o_active  = (r_state != B_IDLE);
    assign o_empty   = !r_ovalid;
    assign o_result  = r_out;

    assign w_rd_en = (r_state == B_READ);
    assign w_load  = !r_ovalid || i_pop;
    assign w_next  = RUN_W'(r_idx) + RUN_W'(1);
    assign w_last  = (r_run == '0) || (w_next == r_run);

    always_ff @(posedge i_clk) begin
        if (i_mem_wr.en) begin
            r_mem[i_mem_wr.addr] <= i_mem_wr.data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[{r_job.bank, r_idx}];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_idx     = r_idx;
        n_run     = r_run;
        n_out     = r_out;
        n_ovalid  = r_ovalid && !i_pop;
        n_release = '{valid: 1'b0, bank: r_job.bank};

        unique case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    n_job = i_job;
                    n_idx = '0;
                    n_run = (i_job.len > CNT_W'(RUN_LEN)) ? RUN_W'(RUN_LEN) : RUN_W'(i_job.len);
                    n_state = (i_job.len == '0) ? B_PUT : B_READ;
                end
            end
            B_READ: begin
                n_state = B_PUT;
            end
            B_PUT: begin
                if (w_load) begin
                    n_ovalid             = 1'b1;
                    n_out.command        = r_job.cmd;
                    n_out.payload_len    = 6'(r_job.len);
                    n_out.byte_index     = 5'(r_idx);
                    n_out.payload_byte   = (r_run == '0) ? 8'd0 : r_rd_data;
                    n_out.has_byte       = (r_run != '0);
                    n_out.last           = w_last;
                    if (w_last) begin
                        n_release.valid = 1'b1;
                        n_state         = B_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = B_READ;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_ovalid  <= 1'b0;
            r_release <= '0;
        end else begin
            r_state   <= n_state;
            r_ovalid  <= n_ovalid;
            r_release <= n_release;
        end
        r_job <= n_job;
        r_idx <= n_idx;
        r_run <= n_run;
        r_out <= n_out;
    end

endmodule

[rtl/delimited_packet_receiver.sv]
// Receives a stream of serial bytes and timer ticks and deframes packets of the form
// 0x7B, command, payload bytes, 0x7D; each delivered packet comes out as a run of
// results, one per stored payload byte (one result without a byte for an empty payload).
// Every byte or tick is accepted in the cycle it is pushed unless full is high. After
// the packet is picked up, each result passes a registered read of the payload memory
// and then the output register; the next byte is read only once the result is loaded.
// Payload is held in two memory banks, so a new packet can be received while the
// previous one is emitted; full rises when both banks wait for emission and clears in
// the cycle after the older packet's last result reaches the output.
// Depends on dpr_pkg, dpr_front, dpr_jobq, dpr_back and the assertion macro header.
module delimited_packet_receiver (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dpr_pkg::t_item   i_item,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output dpr_pkg::t_result o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [dpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dpr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dpr_pkg::*;

    logic     w_job_push;
    t_job     w_job_in;
    t_mem_wr  w_mem_wr;
    t_release w_release;
    logic     w_jobq_full;
    logic     w_jobq_valid;
    t_job     w_job_head;
    logic     w_job_pop;
    logic     w_back_active;

    dpr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_job_push  (w_job_push),
        .o_job       (w_job_in),
        .o_mem_wr    (w_mem_wr),
        .i_release   (w_release)
    );

    dpr_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job_in),
        .o_full  (w_jobq_full),
        .i_pop   (w_job_pop),
        .o_valid (w_jobq_valid),
        .o_head  (w_job_head)
    );

    dpr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mem_wr    (w_mem_wr),
        .i_job_valid (w_jobq_valid),
        .i_job       (w_job_head),
        .o_job_pop   (w_job_pop),
        .o_release   (w_release),
        .o_active    (w_back_active),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_result    (o_result)
    );

`include "delimited_packet_receiver_assert.svh"

    `DPR_ASSERT_SAME(a_jobq_no_overflow, w_job_push, !w_jobq_full, "job queue overflow")
    `DPR_ASSERT_NEXT(a_job_lands, w_job_push, w_jobq_valid, "pushed job not visible")
    `DPR_ASSERT_SAME(a_release_after_last, w_release.valid, !o_empty && o_result.last,
        "bank released before last result reached output")
    `DPR_ASSERT_SAME(a_full_has_owner, o_full,
        w_jobq_valid || w_back_active || w_release.valid, "stalled with no packet pending")

endmodule

[tb/tb.sv]
// self-checking testbench for delimited_packet_receiver: directed packets, timeouts,
// delivery off, a long output stall and random framed traffic against a local predictor
// depends on dpr_pkg and the delimited_packet_receiver rtl
module tb;
    import dpr_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 2 * MAX_RESULTS + 16;
    localparam int POP_HOLD      = 400;
    localparam int RANDOM_ITEMS  = 60;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;

    typedef enum logic [1:0] {RX_IDLE, RX_COMMAND, RX_PAYLOAD} rx_phase_e;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_push      = 1'b0;
    t_item                 i_item      = '0;
    logic                  o_full;
    logic                  o_empty;
    logic                  i_pop       = 1'b0;
    t_result               o_result;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    delimited_packet_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // deframer prediction state
    rx_phase_e   frame_phase = RX_IDLE;
    logic [7:0]  frame_cmd   = '0;
    int          frame_count = 0;
    logic [7:0]  frame_bytes [PAYLOAD_DEPTH];
    logic [15:0] frame_timer = '0;
    logic [15:0] timeout_cfg = TIMEOUT_RESET;
    logic        deliver_cfg = 1'b1;
    t_result     due_results [$];

    int items_sent        = 0;
    int items_live        = 0;
    int ticks_sent        = 0;
    int results_checked   = 0;
    int packets_delivered = 0;
    int packets_timed_out = 0;
    int packets_discarded = 0;
    int full_stall_cycles = 0;
    int errors            = 0;
    int cycles_run        = 0;

    bit calm            = 1'b0;
    int gap_pct         = 25;
    int stall_pct       = 25;
    int pop_hold_cycles = 0;
    int pop_stall_left  = 0;

    // returns 1 when the item changed the deframer state
    function automatic bit deframe_predict(t_item it);
        t_result r;
        int      n;
        if (it.req_type == REQ_TICK) begin
            if (frame_phase == RX_IDLE)
                return 1'b0;
            frame_timer = frame_timer + 16'd1;
            if (frame_timer >= timeout_cfg) begin
                frame_phase = RX_IDLE;
                packets_timed_out++;
            end
            return 1'b1;
        end
        case (frame_phase)
            RX_IDLE: begin
                if (it.rx_byte != START_BYTE)
                    return 1'b0;
                frame_phase = RX_COMMAND;
                frame_timer = '0;
            end
            RX_COMMAND: begin
                frame_cmd   = it.rx_byte;
                frame_phase = RX_PAYLOAD;
                frame_count = 0;
                frame_timer = '0;
            end
            RX_PAYLOAD: begin
                frame_timer = '0;
                if (it.rx_byte == END_BYTE) begin
                    frame_phase = RX_IDLE;
                    if (!deliver_cfg) begin
                        packets_discarded++;
                    end else begin
                        packets_delivered++;
                        n = (frame_count > MAX_RESULTS) ? MAX_RESULTS : frame_count;
                        if (n == 0) begin
                            r         = '0;
                            r.command = frame_cmd;
                            r.last    = 1'b1;
                            due_results.push_back(r);
                        end
                        for (int i = 0; i < n; i++) begin
                            r.command      = frame_cmd;
                            r.payload_len  = 6'(frame_count);
                            r.byte_index   = 5'(i);
                            r.payload_byte = frame_bytes[i];
                            r.has_byte     = 1'b1;
                            r.last         = (i == n - 1);
                            due_results.push_back(r);
                        end
                    end
                end else if (frame_count < PAYLOAD_DEPTH) begin
                    frame_bytes[frame_count] = it.rx_byte;
                    frame_count++;
                end
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_result(t_result got);
        t_result want;
        if (due_results.size() == 0) begin
            $error("result with no packet pending: %p", got);
            errors++;
            return;
        end
        want = due_results.pop_front();
        results_checked++;
        check_field("command", want.command, got.command);
        check_field("payload_len", 8'(want.payload_len), 8'(got.payload_len));
        check_field("byte_index", 8'(want.byte_index), 8'(got.byte_index));
        check_field("payload_byte", want.payload_byte, got.payload_byte);
        check_field("has_byte", 8'(want.has_byte), 8'(got.has_byte));
        check_field("last", 8'(want.last), 8'(got.last));
    endfunction

    // result side: check each pop transaction, then pick the next pop level
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty)
            check_result(o_result);
        if (pop_hold_cycles > 0) begin
            pop_hold_cycles--;
            i_pop <= 1'b0;
        end else if (calm) begin
            i_pop <= 1'b1;
        end else if (pop_stall_left > 0) begin
            pop_stall_left--;
            i_pop <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            pop_stall_left = $urandom_range(0, 5);
            i_pop <= 1'b0;
        end else begin
            i_pop <= 1'b1;
        end
    end

    initial begin
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles_run++;
        end
        $error("run exceeded %0d cycles", CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_item(input t_item it);
        i_push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_full) begin
            full_stall_cycles++;
            @(posedge i_clk);
        end
        items_sent++;
        if (it.req_type == REQ_TICK)
            ticks_sent++;
        if (deframe_predict(it))
            items_live++;
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(t_item'{req_type: REQ_BYTE, rx_byte: b});
    endtask

    task automatic send_tick();
        send_item(t_item'{req_type: REQ_TICK, rx_byte: 8'($urandom)});
    endtask

    function automatic logic [7:0] payload_value();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == END_BYTE)
            b = b ^ 8'h01;
        return b;
    endfunction

    task automatic send_packet(input logic [7:0] cmd, input int len, input int tick_pct,
                               input bit closed);
        send_byte(START_BYTE);
        send_byte(cmd);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < tick_pct)
                send_tick();
            send_byte(payload_value());
        end
        if ($urandom_range(0, 99) < tick_pct)
            send_tick();
        if (closed)
            send_byte(END_BYTE);
    endtask

    task automatic wait_drain();
        i_push <= 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
    endtask

    // close any open packet and let the block go idle before a register write
    task automatic quiesce();
        if (frame_phase == RX_COMMAND)
            send_byte(8'($urandom));
        if (frame_phase == RX_PAYLOAD)
            send_byte(END_BYTE);
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_TIMEOUT: timeout_cfg = data;
            CFG_ENABLE:  deliver_cfg = data[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] timeout, input logic [15:0] enable_word);
        quiesce();
        write_reg(CFG_TIMEOUT, timeout);
        write_reg(CFG_ENABLE, enable_word);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_basic_packet();
        send_byte(8'h00);
        send_tick();
        send_byte(8'hFF);
        send_byte(END_BYTE);
        send_byte(START_BYTE);
        send_byte(8'hA5);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(END_BYTE);
    endtask

    task automatic test_special_bytes();
        // end byte as command, then empty payload
        send_byte(START_BYTE);
        send_byte(END_BYTE);
        send_byte(END_BYTE);
        // start byte as command and as payload
        send_byte(START_BYTE);
        send_byte(START_BYTE);
        send_byte(START_BYTE);
        send_byte(END_BYTE);
    endtask

    task automatic test_timeout();
        set_config(16'd1, 16'd1);
        send_byte(START_BYTE);
        send_tick();
        send_byte(8'h33);
        set_config(16'd2, 16'd1);
        send_byte(START_BYTE);
        send_byte(8'h10);
        send_tick();
        send_byte(8'h01);
        send_tick();
        send_byte(END_BYTE);
        send_byte(START_BYTE);
        send_byte(8'h11);
        send_tick();
        send_tick();
        send_byte(END_BYTE);
        set_config(16'hFFFF, 16'd1);
        send_packet(8'h12, 1, 50, 1);
    endtask

    task automatic test_delivery_disable();
        quiesce();
        write_reg(CFG_SPARE, 16'hFFFF);
        write_reg(CFG_ENABLE, 16'hFFFE);
        i_cfg_valid <= 1'b0;
        send_packet(8'h20, 2, 0, 1);
        set_config(TIMEOUT_RESET, 16'h8001);
        send_packet(8'h21, 0, 0, 1);
    endtask

    task automatic test_backpressure();
        quiesce();
        gap_pct = 0;
        pop_hold_cycles = POP_HOLD;
        repeat (3) send_packet(8'($urandom), 8, 0, 1);
        wait_drain();
        gap_pct = 25;
    endtask

    task automatic test_random_packets(input int count);
        int          target;
        int          kind;
        int          len;
        int          packets_left;
        logic [15:0] timeout;
        logic [15:0] enable_word;
        target       = items_live + count;
        packets_left = 0;
        send_packet(8'($urandom), $urandom_range(PAYLOAD_DEPTH + 1, PAYLOAD_DEPTH + 8), 0, 1);
        while (items_live < target) begin
            if (packets_left == 0) begin
                case ($urandom_range(0, 5))
                    0:       timeout = 16'd1;
                    1:       timeout = 16'hFFFF;
                    2:       timeout = 16'($urandom_range(2, 6));
                    3:       timeout = 16'($urandom_range(7, 40));
                    default: timeout = 16'($urandom_range(1, 16'hFFFF));
                endcase
                enable_word    = 16'($urandom);
                enable_word[0] = ($urandom_range(0, 99) < 85);
                set_config(timeout, enable_word);
                gap_pct      = 15 * $urandom_range(0, 2);
                stall_pct    = 15 * $urandom_range(0, 2);
                packets_left = $urandom_range(4, 10);
            end
            packets_left--;
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, PAYLOAD_DEPTH + 8)
                                                  : $urandom_range(0, 8);
                send_packet(8'($urandom), len, $urandom_range(0, 1) ? 0 : $urandom_range(5, 30), 1);
            end else if (kind < 85) begin
                send_packet(8'($urandom), $urandom_range(0, 4), 0, 0);
                if ($urandom_range(0, 1))
                    repeat ((timeout_cfg > 16'd12) ? 3 : int'(timeout_cfg)) send_tick();
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 1))
                        send_tick();
                    else
                        send_byte(8'($urandom));
                end
            end
        end
    endtask

    task automatic test_calm_finish();
        set_config(TIMEOUT_RESET, 16'd1);
        calm = 1'b1;
        repeat (4) send_packet(8'($urandom), $urandom_range(0, 8), 0, 1);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_packet();
        test_special_bytes();
        test_timeout();
        test_delivery_disable();
        test_backpressure();
        test_random_packets(RANDOM_ITEMS);
        test_calm_finish();
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("sent %0d items (%0d ticks, %0d effective), checked %0d results of %0d packets",
                 items_sent, ticks_sent, items_live, results_checked, packets_delivered);
        $display("%0d packets timed out, %0d discarded, %0d cycles with input full, %0d cycles",
                 packets_timed_out, packets_discarded, full_stall_cycles, cycles_run);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
